// ----- hdl/fvnt_pkg.sv -----
// ============================================================================
// Fractal value noise terrain tiler - shared package
// Widths, hash constants, register codes, band configuration type and the
// smoothstep table builder used by the octave lanes.
// ============================================================================
package fvnt_pkg;

    localparam int CELL_SIDE_DEF    = 64;
    localparam int OCTAVE_COUNT_DEF = 5;
    localparam int BAND_SLOTS_DEF   = 6;

    localparam int CELL_W     = 8;
    localparam int CORNER_W   = 12;
    localparam int HEIGHT_W   = 20;
    localparam int BLOCK_W    = 12;
    localparam int BAND_IDX_W = 3;
    localparam int SEED_W     = 32;
    localparam int AMP_W      = 16;
    localparam int PERS_W     = 16;
    localparam int CEIL_REG_W = 60;
    localparam int BLK_REG_W  = 36;
    localparam int CFG_DATA_W = 60;
    localparam int CFG_ADDR_W = 3;
    localparam int FIELDS_PER_REG = 3;
    localparam int MAX_BANDS  = 6;

    localparam int SCALE_W  = 24;
    localparam int WGT_W    = 17;
    localparam int BLEND_W  = 48;
    localparam int VSUM_W   = 64;
    localparam int NOISE_W  = 32;
    localparam int TERM_W   = 57;
    localparam int SUM_W    = 60;
    localparam int DETAIL_W = 21;

    localparam int SM_DEPTH = 256;
    localparam int SM_IDX_W = 8;

    localparam logic [31:0] HASH_MUL_X = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
    localparam logic [31:0] HASH_MIX   = 32'd1274126177;

    localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SEED,
        CFG_AMP,
        CFG_PERS,
        CFG_CEIL_A,
        CFG_CEIL_B,
        CFG_BLK_A,
        CFG_BLK_B,
        CFG_BAND_CNT
    } t_cfg_reg;

    typedef struct packed {
        logic [CEIL_REG_W-1:0] ceil_a;
        logic [CEIL_REG_W-1:0] ceil_b;
        logic [BLK_REG_W-1:0]  blk_a;
        logic [BLK_REG_W-1:0]  blk_b;
        logic [BAND_IDX_W-1:0] count;
    } t_band_cfg;

    typedef logic [SM_DEPTH-1:0][WGT_W-1:0] t_sm_tbl;

    // Smoothstep weight in Q0.16 for every remainder of a power of two period.
    function automatic t_sm_tbl smooth_table(input int lg);
        t_sm_tbl tbl;
        longint  p;
        longint  p3;
        longint  num;
        tbl = '0;
        p   = longint'(1) << lg;
        p3  = p * p * p;
        for (int r = 0; r < p; r++) begin
            num = (longint'(r) * longint'(r) * (3 * p - 2 * longint'(r))) << 16;
            tbl[SM_IDX_W'(r)] = WGT_W'((num + (p3 >> 1)) >> (3 * lg));
        end
        return tbl;
    endfunction

endpackage

// ----- hdl/fvnt_base.sv -----
// ============================================================================
// Fractal value noise terrain tiler - base height
// Bilinear interpolation of the four corner heights at the pixel centre,
// rounded to Q12.8, then delayed to line up with the noise sum.
// ============================================================================
module fvnt_base #(
    parameter int CELL_SIDE = fvnt_pkg::CELL_SIDE_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [$clog2(CELL_SIDE)-1:0]          i_pixel_x,
    input  logic [$clog2(CELL_SIDE)-1:0]          i_pixel_y,
    input  logic signed [fvnt_pkg::CORNER_W-1:0]  i_tl,
    input  logic signed [fvnt_pkg::CORNER_W-1:0]  i_tr,
    input  logic signed [fvnt_pkg::CORNER_W-1:0]  i_bl,
    input  logic signed [fvnt_pkg::CORNER_W-1:0]  i_br,
    output logic signed [fvnt_pkg::HEIGHT_W-1:0]  o_base
);

    localparam int PIX_W = $clog2(CELL_SIDE);
    localparam int WS_W  = PIX_W + 3;
    localparam int LX_W  = fvnt_pkg::CORNER_W + WS_W + 1;
    localparam int NB_W  = LX_W + WS_W + 1;
    localparam int BX_W  = NB_W + 9;
    localparam int SH    = 2 * PIX_W + 2;
    localparam int DLY   = 5;
    localparam logic signed [WS_W-1:0] SPAN = WS_W'(2 * CELL_SIDE);
    localparam logic signed [BX_W-1:0] RND  = BX_W'(2 * CELL_SIDE * CELL_SIDE);

    logic signed [WS_W-1:0] wx1, wx0, wy1, wy0;
    logic signed [LX_W-1:0] n_lx0, n_lx1;
    logic signed [LX_W-1:0] r_lx0, r_lx1;
    logic signed [WS_W-1:0] r_wy0, r_wy1;
    logic signed [NB_W-1:0] n_nb, r_nb;
    logic signed [BX_W-1:0] tmp, shd;
    logic signed [fvnt_pkg::HEIGHT_W-1:0] r_base;
    logic signed [fvnt_pkg::HEIGHT_W-1:0] r_dly [DLY];

    assign wx1 = $signed(WS_W'({i_pixel_x, 1'b1}));
    assign wx0 = SPAN - wx1;
    assign wy1 = $signed(WS_W'({i_pixel_y, 1'b1}));
    assign wy0 = SPAN - wy1;

    assign n_lx0 = LX_W'(i_tl) * LX_W'(wx0) + LX_W'(i_tr) * LX_W'(wx1);
    assign n_lx1 = LX_W'(i_bl) * LX_W'(wx0) + LX_W'(i_br) * LX_W'(wx1);
    assign n_nb  = NB_W'(r_lx0) * NB_W'(r_wy0) + NB_W'(r_lx1) * NB_W'(r_wy1);

    assign tmp = (BX_W'(r_nb) <<< 8) + RND;
    assign shd = tmp >>> SH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lx0  <= n_lx0;
            r_lx1  <= n_lx1;
            r_wy0  <= wy0;
            r_wy1  <= wy1;
            r_nb   <= n_nb;
            r_base <= shd[fvnt_pkg::HEIGHT_W-1:0];
            r_dly[0] <= r_base;
            for (int i = 1; i < DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    assign o_base = r_dly[DLY-1];

endmodule

// ----- hdl/fvnt_octave.sv -----
// ============================================================================
// Fractal value noise terrain tiler - octave lane
// One octave of hashed lattice value noise: lattice hash, smoothstep blend
// and weighting by the octave scale, over six register stages.
// ============================================================================
module fvnt_octave #(
    parameter int CELL_SIDE = fvnt_pkg::CELL_SIDE_DEF,
    parameter int OCT_IDX   = 0
) (
    input  logic                                         i_clk,
    input  logic                                         i_en,
    input  logic [fvnt_pkg::CELL_W+$clog2(CELL_SIDE)-1:0] i_wx,
    input  logic [fvnt_pkg::CELL_W+$clog2(CELL_SIDE)-1:0] i_wy,
    input  logic [fvnt_pkg::SEED_W-1:0]                  i_seed,
    input  logic [fvnt_pkg::SCALE_W-1:0]                 i_scale,
    output logic signed [fvnt_pkg::TERM_W-1:0]           o_term
);

    localparam int PIX_W = $clog2(CELL_SIDE);
    localparam int WX_W  = fvnt_pkg::CELL_W + PIX_W;
    localparam int LG    = PIX_W - OCT_IDX;
    localparam int IW    = fvnt_pkg::SM_IDX_W;
    localparam int WW    = fvnt_pkg::WGT_W;
    localparam int BW    = fvnt_pkg::BLEND_W;
    localparam int VW    = fvnt_pkg::VSUM_W;
    localparam int TW    = fvnt_pkg::TERM_W;
    localparam fvnt_pkg::t_sm_tbl SM = fvnt_pkg::smooth_table(LG);
    localparam logic [31:0] OFS [4] = '{
        32'd0, fvnt_pkg::HASH_MUL_X, fvnt_pkg::HASH_MUL_Y,
        fvnt_pkg::HASH_MUL_X + fvnt_pkg::HASH_MUL_Y};

    logic [IW-1:0] rx, ry;
    logic [31:0]   hb;
    logic [31:0]   h [4];
    logic [31:0]   g [4];
    logic [BW-1:0] n_t, n_b;
    logic [VW-1:0] v;
    logic signed [TW-1:0] n_e, s_e;

    logic [31:0]   r_ax, r_ay;
    logic [WW-1:0] r_sx_a, r_sx_b, r_sx_c;
    logic [WW-1:0] r_sy_a, r_sy_b, r_sy_c, r_sy_d;
    logic [31:0]   r_m [4];
    logic [31:0]   r_q [4];
    logic [BW-1:0] r_t, r_b;
    logic signed [fvnt_pkg::NOISE_W-1:0] r_n;
    logic signed [TW-1:0] r_term;

    assign rx = IW'(i_wx[LG-1:0]);
    assign ry = IW'(i_wy[LG-1:0]);

    // Corners: (gx,gy), (gx+1,gy), (gx,gy+1), (gx+1,gy+1).
    assign hb = r_ax + r_ay + i_seed;
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            h[c] = hb + OFS[c];
            g[c] = r_q[c] ^ (r_q[c] >> 16);
        end
    end

    assign n_t = BW'(g[0]) * BW'(fvnt_pkg::WGT_ONE - r_sx_c) + BW'(g[1]) * BW'(r_sx_c);
    assign n_b = BW'(g[2]) * BW'(fvnt_pkg::WGT_ONE - r_sx_c) + BW'(g[3]) * BW'(r_sx_c);
    assign v   = VW'(r_t) * VW'(fvnt_pkg::WGT_ONE - r_sy_d) + VW'(r_b) * VW'(r_sy_d);

    assign n_e = TW'(r_n);
    assign s_e = $signed(TW'(i_scale));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax   <= 32'(i_wx[WX_W-1:LG]) * fvnt_pkg::HASH_MUL_X;
            r_ay   <= 32'(i_wy[WX_W-1:LG]) * fvnt_pkg::HASH_MUL_Y;
            r_sx_a <= SM[rx];
            r_sy_a <= SM[ry];
            r_sx_b <= r_sx_a;
            r_sx_c <= r_sx_b;
            r_sy_b <= r_sy_a;
            r_sy_c <= r_sy_b;
            r_sy_d <= r_sy_c;
            for (int c = 0; c < 4; c++) begin
                r_m[c] <= h[c] ^ (h[c] >> 13);
                r_q[c] <= r_m[c] * fvnt_pkg::HASH_MIX;
            end
            r_t    <= n_t;
            r_b    <= n_b;
            r_n    <= $signed({~v[VW-1], v[VW-2:VW-fvnt_pkg::NOISE_W]});
            r_term <= n_e * s_e;
        end
    end

    assign o_term = r_term;

endmodule

// ----- hdl/fvnt_band.sv -----
// ============================================================================
// Fractal value noise terrain tiler - band classifier
// Picks the first band in use whose ceiling is not below the height, or the
// last band in use if there is none, and registers the result item.
// ============================================================================
module fvnt_band #(
    parameter int BAND_SLOTS = fvnt_pkg::BAND_SLOTS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [fvnt_pkg::HEIGHT_W-1:0]  i_height,
    input  fvnt_pkg::t_band_cfg                   i_cfg,
    output logic signed [fvnt_pkg::HEIGHT_W-1:0]  o_height,
    output logic [fvnt_pkg::BLOCK_W-1:0]          o_tile_block,
    output logic [fvnt_pkg::BAND_IDX_W-1:0]       o_band_index
);

    localparam int HW = fvnt_pkg::HEIGHT_W;
    localparam int KW = fvnt_pkg::BLOCK_W;
    localparam int IW = fvnt_pkg::BAND_IDX_W;
    localparam int FP = fvnt_pkg::FIELDS_PER_REG;

    logic signed [HW-1:0] ceil_v [fvnt_pkg::MAX_BANDS];
    logic [KW-1:0]        blk_v  [fvnt_pkg::MAX_BANDS];
    logic [IW-1:0]        cnt;
    logic [IW-1:0]        chosen;

    logic signed [HW-1:0] r_height;
    logic [KW-1:0]        r_tile;
    logic [IW-1:0]        r_band;

    always_comb begin
        for (int i = 0; i < FP; i++) begin
            ceil_v[i]      = $signed(i_cfg.ceil_a[HW*i +: HW]);
            ceil_v[i + FP] = $signed(i_cfg.ceil_b[HW*i +: HW]);
            blk_v[i]       = i_cfg.blk_a[KW*i +: KW];
            blk_v[i + FP]  = i_cfg.blk_b[KW*i +: KW];
        end
    end

    always_comb begin
        if (i_cfg.count == '0) begin
            cnt = IW'(1);
        end else if (i_cfg.count > IW'(BAND_SLOTS)) begin
            cnt = IW'(BAND_SLOTS);
        end else begin
            cnt = i_cfg.count;
        end
        chosen = cnt - IW'(1);
        for (int i = BAND_SLOTS - 1; i >= 0; i--) begin
            if ((IW'(i) < cnt) && (i_height <= ceil_v[i])) begin
                chosen = IW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_height <= i_height;
            r_tile   <= blk_v[chosen];
            r_band   <= chosen;
        end
    end

    assign o_height     = r_height;
    assign o_tile_block = r_tile;
    assign o_band_index = r_band;

endmodule

// ----- hdl/fractal_value_noise_terrain_tiler_unit.sv -----
// ============================================================================
// Fractal value noise terrain tiler - top level
// Terrain height and tile block for one pixel per transfer.
// ============================================================================
// The unit takes one pixel transfer per clock unless the output stalls, and
// returns exactly one result transfer for it, in order. The pipeline depth is
// set by the octave lanes, whose hash multiply, 32 by 17 blend, second blend
// and scale multiply each occupy a register stage, followed by the two-level
// octave sum, the saturating add and the band classifier. Every stage moves
// together: when the result register holds an item that the consumer stalls,
// the whole pipeline, including the input, holds, so nothing is dropped or
// repeated. The octave weights are derived from the amplitude and persistence
// registers by a short registered chain, one octave per cycle; they settle
// before any pixel accepted after a configuration write reaches the scale
// multipliers.
// Configuration is meant to be written while no pixel is in flight.
// ============================================================================
module fractal_value_noise_terrain_tiler_unit #(
    parameter int CELL_SIDE    = fvnt_pkg::CELL_SIDE_DEF,
    parameter int OCTAVE_COUNT = fvnt_pkg::OCTAVE_COUNT_DEF,
    parameter int BAND_SLOTS   = fvnt_pkg::BAND_SLOTS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_wr,
    input  logic [fvnt_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [fvnt_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    // Pixel input channel.
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [fvnt_pkg::CELL_W-1:0]           i_cell_x,
    input  logic [fvnt_pkg::CELL_W-1:0]           i_cell_y,
    input  logic [$clog2(CELL_SIDE)-1:0]          i_pixel_x,
    input  logic [$clog2(CELL_SIDE)-1:0]          i_pixel_y,
    input  logic signed [fvnt_pkg::CORNER_W-1:0]  i_corner_top_left,
    input  logic signed [fvnt_pkg::CORNER_W-1:0]  i_corner_top_right,
    input  logic signed [fvnt_pkg::CORNER_W-1:0]  i_corner_bottom_left,
    input  logic signed [fvnt_pkg::CORNER_W-1:0]  i_corner_bottom_right,
    // Result output channel.
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [fvnt_pkg::HEIGHT_W-1:0]  o_terrain_height,
    output logic [fvnt_pkg::BLOCK_W-1:0]          o_tile_block,
    output logic [fvnt_pkg::BAND_IDX_W-1:0]       o_band_index
);

    localparam int PIX_W  = $clog2(CELL_SIDE);
    localparam int WX_W   = fvnt_pkg::CELL_W + PIX_W;
    // Octaves stop once the period would reach one pixel.
    localparam int NOCT   = (OCTAVE_COUNT < PIX_W) ? OCTAVE_COUNT : PIX_W;
    localparam int NPAIR  = (NOCT + 1) / 2;
    localparam int STAGES = 10;
    localparam int SW     = fvnt_pkg::SCALE_W;
    localparam int PW     = fvnt_pkg::PERS_W;
    localparam int MW     = SW + PW + 1;
    localparam int HW     = fvnt_pkg::HEIGHT_W;
    localparam int DW     = fvnt_pkg::DETAIL_W;
    localparam int XW     = HW + 2;
    localparam logic signed [fvnt_pkg::SUM_W-1:0] DET_RND = fvnt_pkg::SUM_W'(64'd1 << 39);
    localparam logic signed [XW-1:0] H_MAX = XW'(524287);
    localparam logic signed [XW-1:0] H_MIN = -XW'(524288);

    // Configuration registers.
    logic [fvnt_pkg::SEED_W-1:0]     r_seed;
    logic [fvnt_pkg::AMP_W-1:0]      r_amp;
    logic [PW-1:0]                   r_pers;
    logic [fvnt_pkg::CEIL_REG_W-1:0] r_ceil_a, r_ceil_b;
    logic [fvnt_pkg::BLK_REG_W-1:0]  r_blk_a, r_blk_b;
    logic [fvnt_pkg::BAND_IDX_W-1:0] r_band_cnt;
    fvnt_pkg::t_band_cfg             band_cfg;

    // Pipeline control.
    logic              en;
    logic [STAGES:1]   r_vld;

    logic [WX_W-1:0]   wx, wy;
    logic [PW-1:0]     pers;
    logic [SW-1:0]     w_scale [NOCT];
    logic signed [fvnt_pkg::TERM_W-1:0] w_term [NOCT];
    logic signed [HW-1:0] base_h;

    logic signed [fvnt_pkg::SUM_W-1:0] r_pair [NPAIR];
    logic signed [fvnt_pkg::SUM_W-1:0] total, total_sh;
    logic signed [DW-1:0]  r_detail;
    logic signed [XW-1:0]  hsum;
    logic signed [HW-1:0]  n_height, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= '0;
            r_amp      <= '0;
            r_pers     <= '0;
            r_ceil_a   <= 60'd8444249839237632;
            r_ceil_b   <= 60'd576459674266646272;
            r_blk_a    <= 36'd17750466594;
            r_blk_b    <= 36'd26195665517;
            r_band_cnt <= 3'd6;
        end else if (i_cfg_wr) begin
            case (fvnt_pkg::t_cfg_reg'(i_cfg_addr))
                fvnt_pkg::CFG_SEED:     r_seed     <= i_cfg_wdata[fvnt_pkg::SEED_W-1:0];
                fvnt_pkg::CFG_AMP:      r_amp      <= i_cfg_wdata[fvnt_pkg::AMP_W-1:0];
                fvnt_pkg::CFG_PERS:     r_pers     <= i_cfg_wdata[PW-1:0];
                fvnt_pkg::CFG_CEIL_A:   r_ceil_a   <= i_cfg_wdata[fvnt_pkg::CEIL_REG_W-1:0];
                fvnt_pkg::CFG_CEIL_B:   r_ceil_b   <= i_cfg_wdata[fvnt_pkg::CEIL_REG_W-1:0];
                fvnt_pkg::CFG_BLK_A:    r_blk_a    <= i_cfg_wdata[fvnt_pkg::BLK_REG_W-1:0];
                fvnt_pkg::CFG_BLK_B:    r_blk_b    <= i_cfg_wdata[fvnt_pkg::BLK_REG_W-1:0];
                fvnt_pkg::CFG_BAND_CNT: r_band_cnt <= i_cfg_wdata[fvnt_pkg::BAND_IDX_W-1:0];
                default: ;
            endcase
        end
    end

    assign band_cfg.ceil_a = r_ceil_a;
    assign band_cfg.ceil_b = r_ceil_b;
    assign band_cfg.blk_a  = r_blk_a;
    assign band_cfg.blk_b  = r_blk_b;
    assign band_cfg.count  = r_band_cnt;

    // The whole pipeline advances unless a finished result is being held.
    assign en          = !(r_vld[STAGES] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[STAGES-1:1], i_in_valid};
        end
    end

    // World coordinates: the cell index sits above the pixel bits.
    assign wx = {i_cell_x, i_pixel_x};
    assign wy = {i_cell_y, i_pixel_y};

    // Octave weights. A zero amplitude means 1.0 and a zero persistence 0.5.
    // Each later octave is the previous one times persistence, rounded and
    // saturated just below 256.0.
    assign pers       = (r_pers == '0) ? PW'(16'h4000) : r_pers;
    assign w_scale[0] = {((r_amp == '0) ? fvnt_pkg::AMP_W'(16'h0100) : r_amp), 8'h00};

    for (genvar k = 1; k < NOCT; k++) begin : g_scale
        logic [MW-1:0] prod;
        logic [SW-1:0] r_scale;
        assign prod = MW'(w_scale[k-1]) * MW'(pers) + MW'(16384);
        always_ff @(posedge i_clk) begin
            if ((prod >> 15) > MW'({SW{1'b1}})) begin
                r_scale <= {SW{1'b1}};
            end else begin
                r_scale <= prod[SW+14:15];
            end
        end
        assign w_scale[k] = r_scale;
    end

    fvnt_base #(
        .CELL_SIDE (CELL_SIDE)
    ) u_base (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_tl      (i_corner_top_left),
        .i_tr      (i_corner_top_right),
        .i_bl      (i_corner_bottom_left),
        .i_br      (i_corner_bottom_right),
        .o_base    (base_h)
    );

    for (genvar k = 0; k < NOCT; k++) begin : g_oct
        fvnt_octave #(
            .CELL_SIDE (CELL_SIDE),
            .OCT_IDX   (k)
        ) u_oct (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_wx    (wx),
            .i_wy    (wy),
            .i_seed  (r_seed),
            .i_scale (w_scale[k]),
            .o_term  (w_term[k])
        );
    end

    // First level of the octave sum: neighboring octaves in pairs.
    for (genvar j = 0; j < NPAIR; j++) begin : g_pair
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (2 * j + 1 < NOCT) begin
                    r_pair[j] <= fvnt_pkg::SUM_W'(w_term[2*j])
                               + fvnt_pkg::SUM_W'(w_term[(2*j+1) % NOCT]);
                end else begin
                    r_pair[j] <= fvnt_pkg::SUM_W'(w_term[2*j]);
                end
            end
        end
    end

    // Second level: pairs plus the rounding term, then floor to Q13.8.
    always_comb begin
        total = DET_RND;
        for (int j = 0; j < NPAIR; j++) begin
            total = total + r_pair[j];
        end
    end
    assign total_sh = total >>> 40;

    // Base plus detail, saturated to the signed 20-bit height range.
    assign hsum = XW'(base_h) + XW'(r_detail);
    always_comb begin
        if (hsum > H_MAX) begin
            n_height = H_MAX[HW-1:0];
        end else if (hsum < H_MIN) begin
            n_height = H_MIN[HW-1:0];
        end else begin
            n_height = hsum[HW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_detail <= total_sh[DW-1:0];
            r_height <= n_height;
        end
    end

    fvnt_band #(
        .BAND_SLOTS (BAND_SLOTS)
    ) u_band (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_height     (r_height),
        .i_cfg        (band_cfg),
        .o_height     (o_terrain_height),
        .o_tile_block (o_tile_block),
        .o_band_index (o_band_index)
    );

`ifndef NO_ASSERTIONS
    // Input is only held back while a finished result waits.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled without a held result");

    // An accepted pixel always occupies the first stage next cycle.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_vld[1])
        else $error("accepted pixel lost at pipeline entry");

    // The chosen band is always one of the available slots.
    a_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_band_index < fvnt_pkg::BAND_IDX_W'(BAND_SLOTS)))
        else $error("band index outside the band slots");
`endif

endmodule

// ----- verif/tb_fractal_value_noise_terrain_tiler_unit.sv -----
// ----------------------------------------------------------------------------
// Terrain tiler unit testbench
// Streams pixel transfers through the unit with random idling on both sides,
// predicts height, tile block and band for each pixel in the testbench, and
// compares every result transfer in order against that prediction.
// ----------------------------------------------------------------------------
module tb_fractal_value_noise_terrain_tiler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE = 64;
    localparam int OCTAVES = 5;
    localparam int PIPE_DEPTH = 10;

    typedef struct {
        logic [19:0] height;
        logic [11:0] blk;
        logic [2:0]  band;
    } t_tile;

    // Holds the expected tiles, in order, and counts failures.
    class tile_scoreboard;
        t_tile pending[$];
        int    errors = 0;

        function void note_pixel(t_tile t);
            pending.push_back(t);
        endfunction

        function void check_tile(logic [19:0] h, logic [11:0] b, logic [2:0] bi);
            t_tile e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result h=%0h blk=%0h band=%0d", $realtime, h, b, bi);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.height !== h) begin
                $display("%0t: height expected %0h actual %0h", $realtime, e.height, h);
                errors++;
            end
            if (e.blk !== b) begin
                $display("%0t: block expected %0h actual %0h", $realtime, e.blk, b);
                errors++;
            end
            if (e.band !== bi) begin
                $display("%0t: band expected %0d actual %0d", $realtime, e.band, bi);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [59:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_cell_x = '0, i_cell_y = '0;
    logic [5:0]  i_pixel_x = '0, i_pixel_y = '0;
    logic signed [11:0] i_corner_top_left = '0, i_corner_top_right = '0;
    logic signed [11:0] i_corner_bottom_left = '0, i_corner_bottom_right = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic signed [19:0] o_terrain_height;
    logic [11:0] o_tile_block;
    logic [2:0]  o_band_index;

    always #6 i_clk = ~i_clk;

    fractal_value_noise_terrain_tiler_unit uut (.*);

    // Testbench copy of the configuration registers.
    logic [31:0] seed_q;
    logic [15:0] amp_q, pers_q;
    logic [59:0] ceil_a_q, ceil_b_q;
    logic [35:0] blk_a_q, blk_b_q;
    logic [2:0]  count_q;

    tile_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off = 1'b0;
    int pixels_sent = 0;
    int tiles_seen = 0;

    function automatic logic [31:0] lattice_value(logic [31:0] gx, logic [31:0] gy);
        logic [31:0] h;
        h = gx * fvnt_pkg::HASH_MUL_X + gy * fvnt_pkg::HASH_MUL_Y + seed_q;
        h = (h ^ (h >> 13)) * fvnt_pkg::HASH_MIX;
        return h ^ (h >> 16);
    endfunction

    function automatic longint fade(longint r, longint p);
        longint p3;
        p3 = p * p * p;
        return (r * r * (3 * p - 2 * r) * 65536 + p3 / 2) / p3;
    endfunction

    function automatic longint floor_div(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0) q--;
        return q;
    endfunction

    // Height, band and block that the unit must produce for one pixel.
    function automatic t_tile predict_tile(logic [7:0] cx, logic [7:0] cy,
                                           logic [5:0] px, logic [5:0] py,
                                           logic signed [11:0] tl, logic signed [11:0] tr,
                                           logic signed [11:0] bl, logic signed [11:0] br);
        t_tile    t;
        longint   s, wx1, wx0, wy1, wy0, n, base, sum, hgt, ceil_v, sxl, syl;
        longint   wxw, wyw, p, scale, pers, cnt, chosen;
        logic [63:0] v, tt, bb, sx, sy, h00, h10, h01, h11;
        logic [59:0] cw;
        logic [35:0] bw;
        s = 2 * SIDE;
        wx1 = 2 * longint'(px) + 1; wx0 = s - wx1;
        wy1 = 2 * longint'(py) + 1; wy0 = s - wy1;
        n = (longint'(tl) * wx0 + longint'(tr) * wx1) * wy0
          + (longint'(bl) * wx0 + longint'(br) * wx1) * wy1;
        base = floor_div(n * 256 + s * s / 2, s * s);
        wxw = longint'(cx) * SIDE + longint'(px);
        wyw = longint'(cy) * SIDE + longint'(py);
        scale = (amp_q != 0 ? longint'(amp_q) : 256) << 8;
        pers = pers_q != 0 ? longint'(pers_q) : 16384;
        p = SIDE;
        sum = 0;
        for (int o = 0; o < OCTAVES && p > 1; o++) begin
            sxl = fade(wxw % p, p); syl = fade(wyw % p, p);
            sx = sxl; sy = syl;
            h00 = 64'(lattice_value(32'(wxw / p), 32'(wyw / p)));
            h10 = 64'(lattice_value(32'(wxw / p + 1), 32'(wyw / p)));
            h01 = 64'(lattice_value(32'(wxw / p), 32'(wyw / p + 1)));
            h11 = 64'(lattice_value(32'(wxw / p + 1), 32'(wyw / p + 1)));
            tt = h00 * (64'd65536 - sx) + h10 * sx;
            bb = h01 * (64'd65536 - sx) + h11 * sx;
            v = tt * (64'd65536 - sy) + bb * sy;
            sum += (longint'(v >> 32) - 64'sd2147483648) * scale;
            scale = (scale * pers + 16384) >>> 15;
            if (scale > 64'hFFFFFF) scale = 64'hFFFFFF;
            p /= 2;
        end
        hgt = base + floor_div(sum + (longint'(1) << 39), longint'(1) << 40);
        if (hgt > 524287) hgt = 524287;
        if (hgt < -524288) hgt = -524288;
        cnt = longint'(count_q);
        if (cnt < 1) cnt = 1;
        if (cnt > fvnt_pkg::MAX_BANDS) cnt = fvnt_pkg::MAX_BANDS;
        chosen = cnt - 1;
        for (int i = 0; i < cnt; i++) begin
            cw = i < 3 ? ceil_a_q : ceil_b_q;
            ceil_v = longint'($signed(cw[20 * (i % 3) +: 20]));
            if (hgt <= ceil_v) begin
                chosen = i;
                break;
            end
        end
        bw = chosen < 3 ? blk_a_q : blk_b_q;
        t.height = hgt[19:0];
        t.blk = bw[12 * (chosen % 3) +: 12];
        t.band = chosen[2:0];
        return t;
    endfunction

    // Writes one register of the unit and of the testbench copy. The write
    // enable stays up until the next pixel is offered, so writes can follow
    // each other in consecutive cycles.
    task automatic write_reg(fvnt_pkg::t_cfg_reg idx, logic [59:0] val);
        i_cfg_wr <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            fvnt_pkg::CFG_SEED:     seed_q = val[31:0];
            fvnt_pkg::CFG_AMP:      amp_q = val[15:0];
            fvnt_pkg::CFG_PERS:     pers_q = val[15:0];
            fvnt_pkg::CFG_CEIL_A:   ceil_a_q = val;
            fvnt_pkg::CFG_CEIL_B:   ceil_b_q = val;
            fvnt_pkg::CFG_BLK_A:    blk_a_q = val[35:0];
            fvnt_pkg::CFG_BLK_B:    blk_b_q = val[35:0];
            fvnt_pkg::CFG_BAND_CNT: count_q = val[2:0];
            default: ;
        endcase
    endtask

    // Offers one pixel and holds it until the unit accepts the transfer.
    // Valid stays up after the transfer; idling or draining drops it.
    task automatic send_pixel(logic [7:0] cx, logic [7:0] cy, logic [5:0] px,
                              logic [5:0] py, logic [11:0] tl, logic [11:0] tr,
                              logic [11:0] bl, logic [11:0] br);
        i_cfg_wr <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cell_x <= cx; i_cell_y <= cy; i_pixel_x <= px; i_pixel_y <= py;
        i_corner_top_left <= tl; i_corner_top_right <= tr;
        i_corner_bottom_left <= bl; i_corner_bottom_right <= br;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pixel(predict_tile(cx, cy, px, py, tl, tr, bl, br));
        pixels_sent++;
    endtask

    task automatic send_random_pixel();
        logic [11:0] c[4];
        int mode;
        mode = $urandom_range(9);
        for (int k = 0; k < 4; k++) begin
            if (mode == 0) c[k] = $urandom_range(1) ? 12'h7FF : 12'h800;
            else c[k] = 12'($urandom);
        end
        send_pixel(8'($urandom), 8'($urandom), 6'($urandom), 6'($urandom),
                   c[0], c[1], c[2], c[3]);
    endtask

    // Waits until every expected tile has come back, then lets the pipe drain.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    // The receiver stalls at random, or for a long stretch on request.
    always @(posedge i_clk) begin
        i_out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // Results are checked on the edge where the transfer happens.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_tile(o_terrain_height, o_tile_block, o_band_index);
            tiles_seen++;
        end
    end

    initial begin
        #20ms;
        $display("FAIL fractal_value_noise_terrain_tiler_unit");
        $finish;
    end

    initial begin
        seed_q = '0; amp_q = '0; pers_q = '0;
        ceil_a_q = 60'd8444249839237632;
        ceil_b_q = 60'd576459674266646272;
        blk_a_q = 36'd17750466594;
        blk_b_q = 36'd26195665517;
        count_q = 3'd6;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels at reset configuration: corner and pixel extremes.
        send_pixel(8'd0, 8'd0, 6'd0, 6'd0, 12'h000, 12'h000, 12'h000, 12'h000);
        send_pixel(8'hFF, 8'hFF, 6'd63, 6'd63, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF);
        send_pixel(8'hFF, 8'd0, 6'd63, 6'd0, 12'h800, 12'h800, 12'h800, 12'h800);
        send_pixel(8'd0, 8'hFF, 6'd0, 6'd63, 12'h7FF, 12'h800, 12'h800, 12'h7FF);
        send_pixel(8'h80, 8'h7F, 6'd32, 6'd31, 12'h800, 12'h7FF, 12'h7FF, 12'h800);
        drain();

        // Largest weights saturate the scale; band count zero counts as one.
        write_reg(fvnt_pkg::CFG_SEED, 60'hFFFFFFFF);
        write_reg(fvnt_pkg::CFG_AMP, 60'hFFFF);
        write_reg(fvnt_pkg::CFG_PERS, 60'hFFFF);
        write_reg(fvnt_pkg::CFG_BAND_CNT, 60'd0);
        send_pixel(8'd3, 8'd5, 6'd17, 6'd40, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF);
        send_pixel(8'd9, 8'd1, 6'd2, 6'd60, 12'h800, 12'h800, 12'h800, 12'h800);
        drain();

        // Band count of seven is clipped to six; no ceiling matches the top.
        write_reg(fvnt_pkg::CFG_BAND_CNT, 60'd7);
        write_reg(fvnt_pkg::CFG_CEIL_A, {20'h80000, 20'h80000, 20'h80000});
        write_reg(fvnt_pkg::CFG_CEIL_B, {20'h80000, 20'h80001, 20'h80000});
        write_reg(fvnt_pkg::CFG_BLK_A, 60'(36'hABC_DEF_123));
        write_reg(fvnt_pkg::CFG_BLK_B, 60'(36'hFFF_456_789));
        for (int k = 0; k < 6; k++) send_random_pixel();
        drain();

        // Random phases, each with its own settings and idling pattern.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(fvnt_pkg::CFG_SEED, {28'd0, 32'($urandom)});
            write_reg(fvnt_pkg::CFG_AMP,
                      (ph % 3 == 0) ? 60'd0 : 60'($urandom_range(16'hFFFF)));
            write_reg(fvnt_pkg::CFG_PERS,
                      (ph % 4 == 1) ? 60'd0 : 60'($urandom_range(16'hFFFF)));
            write_reg(fvnt_pkg::CFG_CEIL_A, 60'({$urandom, $urandom}));
            write_reg(fvnt_pkg::CFG_CEIL_B, 60'({$urandom, $urandom}));
            write_reg(fvnt_pkg::CFG_BLK_A, 60'({$urandom, $urandom}));
            write_reg(fvnt_pkg::CFG_BLK_B, 60'({$urandom, $urandom}));
            write_reg(fvnt_pkg::CFG_BAND_CNT, 60'($urandom_range(7)));
            if (ph < 3) begin
                send_idle_pct = 29; recv_idle_pct = 53;
            end else if (ph < 6) begin
                send_idle_pct = 53; recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            if (ph == 4) begin
                // Hold the receiver off long enough that the pipe backs up.
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (60) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 78; k++) send_random_pixel();
            // Sender pauses until all outstanding tiles are back.
            drain();
        end

        $display("Covered %0d pixel transfers and %0d result transfers over 11 settings,",
                 pixels_sent, tiles_seen);
        $display("including saturated weights, clipped band counts and a long output hold.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS fractal_value_noise_terrain_tiler_unit");
        else
            $display("FAIL fractal_value_noise_terrain_tiler_unit");
        $finish;
    end
endmodule
